### hw/rtl/srw_pkg.sv
// Package for the sequence reorder window: sizes, types and sequencer states.
// Used by srw_window, srw_ctrl and sequence_reorder_window. No dependencies.
package srw_pkg;

  localparam int unsigned WINDOW_DEPTH = 20;
  localparam int unsigned SEQ_WIDTH    = 32;
  localparam int unsigned HANDLE_WIDTH = 16;
  localparam int unsigned IDX_W        = $clog2(WINDOW_DEPTH);
  localparam int unsigned CNT_W        = $clog2(WINDOW_DEPTH + 1);

  typedef logic [SEQ_WIDTH-1:0]    seq_t;
  typedef logic [HANDLE_WIDTH-1:0] handle_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  localparam idx_t LAST_IDX    = idx_t'(WINDOW_DEPTH - 1);
  localparam idx_t PENULT_IDX  = idx_t'(WINDOW_DEPTH - 2);
  localparam cnt_t AFTER_REL   = cnt_t'(WINDOW_DEPTH - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_SHIFT
  } state_t;

  // Write request from the sequencer to the slot storage.
  typedef struct packed {
    logic    we;
    idx_t    addr;
    seq_t    seq;
    handle_t handle;
  } slot_wr_t;

  // Result handed from the sequencer to the output register.
  typedef struct packed {
    logic    load;
    logic    resync;
    seq_t    seq;
    handle_t handle;
  } rel_t;

endpackage

### hw/rtl/srw_window.sv
// Slot storage of the reorder window: one write port and one read port.
// Depends on srw_pkg.
module srw_window (
  input  logic              clk,
  input  srw_pkg::slot_wr_t wr,
  input  srw_pkg::idx_t     rd_addr,
  output srw_pkg::seq_t     rd_seq,
  output srw_pkg::handle_t  rd_handle
);

  srw_pkg::seq_t    slot_seq_r    [srw_pkg::WINDOW_DEPTH];
  srw_pkg::handle_t slot_handle_r [srw_pkg::WINDOW_DEPTH];
  srw_pkg::seq_t    rd_seq_r;
  srw_pkg::handle_t rd_handle_r;

  // Slot contents carry no reset; only filled slots are ever read.
  always_ff @(posedge clk) begin
    if (wr.we) begin
      slot_seq_r[wr.addr]    <= wr.seq;
      slot_handle_r[wr.addr] <= wr.handle;
    end
  end

  // Single registered read port: data for an address appears in the following cycle.
  always_ff @(posedge clk) begin
    rd_seq_r    <= slot_seq_r[rd_addr];
    rd_handle_r <= slot_handle_r[rd_addr];
  end

  assign rd_seq    = rd_seq_r;
  assign rd_handle = rd_handle_r;

endmodule

### hw/rtl/srw_ctrl.sv
// Sequencer of the reorder window: fill count, expected number, the shared
// slot comparator and the compaction walk. Depends on srw_pkg.
module srw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  srw_pkg::seq_t     in_seq,
  input  srw_pkg::handle_t  in_handle,
  input  logic              out_free,
  output srw_pkg::rel_t     rel,
  output srw_pkg::slot_wr_t wr,
  output srw_pkg::idx_t     rd_addr,
  input  srw_pkg::seq_t     rd_seq,
  input  srw_pkg::handle_t  rd_handle
);

  srw_pkg::state_t state_r, state_nxt;
  srw_pkg::idx_t   idx_r, idx_nxt;
  srw_pkg::cnt_t   fill_r, fill_nxt;
  srw_pkg::seq_t   exp_r, exp_nxt;
  logic            hit_r, hit_nxt;
  logic            accept;
  logic            match;
  logic            last_append;

  assign accept      = in_valid && in_ready;
  // The one comparator, stepped across the slots during the scan. The read
  // data always belongs to the slot the read address named in the previous cycle.
  assign match       = (rd_seq == exp_r);
  assign last_append = (fill_r == srw_pkg::AFTER_REL);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      srw_pkg::ST_IDLE: begin
        if (accept && last_append) begin
          state_nxt = srw_pkg::ST_SCAN;
        end
      end
      srw_pkg::ST_SCAN: begin
        if (match || idx_r == srw_pkg::LAST_IDX) begin
          state_nxt = srw_pkg::ST_EMIT;
        end
      end
      srw_pkg::ST_EMIT: begin
        if (out_free) begin
          if (hit_r && idx_r != srw_pkg::LAST_IDX) begin
            state_nxt = srw_pkg::ST_SHIFT;
          end else begin
            state_nxt = srw_pkg::ST_IDLE;
          end
        end
      end
      srw_pkg::ST_SHIFT: begin
        if (idx_r == srw_pkg::PENULT_IDX) begin
          state_nxt = srw_pkg::ST_IDLE;
        end
      end
      default: state_nxt = srw_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath updates.
  always_comb begin
    in_ready   = 1'b0;
    idx_nxt    = idx_r;
    fill_nxt   = fill_r;
    exp_nxt    = exp_r;
    hit_nxt    = hit_r;
    rd_addr    = idx_r;
    wr.we      = 1'b0;
    wr.addr    = idx_r;
    wr.seq     = rd_seq;
    wr.handle  = rd_handle;
    rel.load   = 1'b0;
    rel.resync = 1'b0;
    rel.seq    = rd_seq;
    rel.handle = rd_handle;
    case (state_r)
      srw_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        rd_addr   = '0;
        wr.addr   = srw_pkg::idx_t'(fill_r);
        wr.seq    = in_seq;
        wr.handle = in_handle;
        if (accept) begin
          // Append at the tail; a zero expected value takes this number.
          wr.we    = 1'b1;
          fill_nxt = fill_r + 1'b1;
          idx_nxt  = '0;
          if (exp_r == '0) begin
            exp_nxt = in_seq;
          end
        end
      end
      srw_pkg::ST_SCAN: begin
        if (match) begin
          hit_nxt = 1'b1;
        end else if (idx_r == srw_pkg::LAST_IDX) begin
          hit_nxt = 1'b0;
        end else begin
          idx_nxt = idx_r + 1'b1;
          rd_addr = idx_r + 1'b1;
        end
      end
      srw_pkg::ST_EMIT: begin
        if (out_free) begin
          rel.load = 1'b1;
          if (hit_r) begin
            exp_nxt  = exp_r + 1'b1;
            fill_nxt = srw_pkg::AFTER_REL;
            // Fetch the slot behind the released one for the compaction walk.
            if (idx_r != srw_pkg::LAST_IDX) begin
              rd_addr = idx_r + 1'b1;
            end
          end else begin
            // Expected number missing: flush the window and restart.
            rel.resync = 1'b1;
            rel.seq    = '0;
            rel.handle = '0;
            exp_nxt    = '0;
            fill_nxt   = '0;
          end
        end
      end
      srw_pkg::ST_SHIFT: begin
        // Move the next slot up one place, closing the released gap, while
        // the slot after it is fetched.
        wr.we   = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r != srw_pkg::PENULT_IDX) begin
          rd_addr = idx_r + srw_pkg::idx_t'(2);
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srw_pkg::ST_IDLE;
      fill_r  <= '0;
      exp_r   <= '0;
      idx_r   <= '0;
      hit_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      exp_r   <= exp_nxt;
      idx_r   <= idx_nxt;
      hit_r   <= hit_nxt;
    end
  end

endmodule

### hw/rtl/sequence_reorder_window.sv
// Top level of the sequence reorder window: slot storage, sequencer and
// output register. Depends on srw_pkg, srw_window and srw_ctrl.
//
//   Channel  Ports                                         Direction
//   in       in_valid/in_ready, in_seq_number,              input
//            in_packet_handle
//   out      out_valid/out_ready, out_released_handle,      output
//            out_released_seq, out_resync
//
// A packet that does not fill the window is simply appended. A packet that fills
// it starts a scan with one shared comparator, one slot per cycle: a match in
// slot k is followed by one release and a compaction walk that moves the slots
// behind k up one place; a miss, after every slot is scanned, gives a resync result.
// Reset (rst_n, synchronous) empties the window and clears the expected value.
// A result waiting in the output register holds the next release cycle until taken.
module sequence_reorder_window (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [srw_pkg::SEQ_WIDTH-1:0]    in_seq_number,
  input  logic [srw_pkg::HANDLE_WIDTH-1:0] in_packet_handle,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [srw_pkg::HANDLE_WIDTH-1:0] out_released_handle,
  output logic [srw_pkg::SEQ_WIDTH-1:0]    out_released_seq,
  output logic                            out_resync
);

  srw_pkg::slot_wr_t wr;
  srw_pkg::idx_t     rd_addr;
  srw_pkg::seq_t     rd_seq;
  srw_pkg::handle_t  rd_handle;
  srw_pkg::rel_t     rel;
  logic              out_free;

  logic              out_valid_r;
  srw_pkg::handle_t  out_handle_r;
  srw_pkg::seq_t     out_seq_r;
  logic              out_resync_r;

  srw_window u_window (
    .clk       (clk),
    .wr        (wr),
    .rd_addr   (rd_addr),
    .rd_seq    (rd_seq),
    .rd_handle (rd_handle)
  );

  srw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_seq    (in_seq_number),
    .in_handle (in_packet_handle),
    .out_free  (out_free),
    .rel       (rel),
    .wr        (wr),
    .rd_addr   (rd_addr),
    .rd_seq    (rd_seq),
    .rd_handle (rd_handle)
  );

  // The output register is free when empty or being taken this cycle.
  assign out_free = !out_valid_r || out_ready;

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rel.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload, loaded only when a result is released.
  always_ff @(posedge clk) begin
    if (rel.load) begin
      out_handle_r <= rel.handle;
      out_seq_r    <= rel.seq;
      out_resync_r <= rel.resync;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_released_handle = out_handle_r;
  assign out_released_seq    = out_seq_r;
  assign out_resync          = out_resync_r;

endmodule

### bench/tb.sv
// Self-checking testbench for sequence_reorder_window: directed and random
// packet descriptor streams, with an in-bench predictor. Depends on srw_pkg.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned DRAIN_CYCLES = 48;
  localparam int unsigned PHASE_ITEMS  = 450;

  // One released transaction as the result channel carries it.
  typedef struct packed {
    srw_pkg::handle_t handle;
    srw_pkg::seq_t    seq;
    logic             resync;
  } release_t;

  // Predicts releases from accepted packets and checks the result channel.
  class reorder_scoreboard;
    srw_pkg::seq_t    win_seq[$];
    srw_pkg::handle_t win_handle[$];
    srw_pkg::seq_t    next_seq;
    release_t         due_releases[$];
    int               errors;
    int               packets;
    int               releases;
    int               resyncs;

    function new();
      next_seq = '0;
      errors   = 0;
      packets  = 0;
      releases = 0;
      resyncs  = 0;
    endfunction

    // Apply one accepted packet to the window and queue its release, if any.
    function void note_packet(srw_pkg::seq_t s, srw_pkg::handle_t h);
      release_t r;
      packets++;
      if (next_seq == '0) next_seq = s;
      if (win_seq.size() < srw_pkg::WINDOW_DEPTH) begin
        win_seq.push_back(s);
        win_handle.push_back(h);
      end
      if (win_seq.size() < srw_pkg::WINDOW_DEPTH) return;
      // The oldest entry carrying the awaited number goes out first.
      foreach (win_seq[i]) begin
        if (win_seq[i] == next_seq) begin
          r.handle = win_handle[i];
          r.seq    = win_seq[i];
          r.resync = 1'b0;
          due_releases.push_back(r);
          win_seq.delete(i);
          win_handle.delete(i);
          next_seq = next_seq + srw_pkg::seq_t'(1);
          return;
        end
      end
      // The awaited number is missing: drop everything and start over.
      win_seq.delete();
      win_handle.delete();
      next_seq = '0;
      r = '{handle: '0, seq: '0, resync: 1'b1};
      due_releases.push_back(r);
    endfunction

    function void report(string what, logic [31:0] want, logic [31:0] got);
      errors++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
    endfunction

    // Compare one accepted result with the oldest predicted release.
    function void check_release(srw_pkg::handle_t h, srw_pkg::seq_t s, logic rs);
      release_t want;
      if (due_releases.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: handle %0h seq %0h resync %0b",
                 $time, h, s, rs);
        return;
      end
      want = due_releases.pop_front();
      if (want.handle !== h)  report("released_handle", want.handle, h);
      if (want.seq !== s)     report("released_seq", want.seq, s);
      if (want.resync !== rs) report("resync", want.resync, rs);
      if (want.resync) resyncs++;
      else releases++;
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  srw_pkg::seq_t    in_seq_number = '0;
  srw_pkg::handle_t in_packet_handle = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  srw_pkg::handle_t out_released_handle;
  srw_pkg::seq_t    out_released_seq;
  logic             out_resync;

  reorder_scoreboard sb = new();
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 18;
  int unsigned recv_idle_pct = 87;
  int unsigned sent = 0;

  sequence_reorder_window dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_seq_number       (in_seq_number),
    .in_packet_handle    (in_packet_handle),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_released_handle (out_released_handle),
    .out_released_seq    (out_released_seq),
    .out_resync          (out_resync)
  );

  always #1 clk = ~clk;

  // Watchdog on a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d releases outstanding", $time,
               sb.due_releases.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  // Receiver back-pressure, changed on the falling edge.
  always @(negedge clk) begin
    out_ready = rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_release(out_released_handle, out_released_seq, out_resync);
  end

  // Offer one packet transaction, with random idle cycles ahead of it.
  task automatic send_packet(srw_pkg::seq_t s, srw_pkg::handle_t h);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid         = 1'b1;
    in_seq_number    = s;
    in_packet_handle = h;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    sb.note_packet(s, h);
    sent++;
    @(negedge clk);
  endtask

  // Field extremes, a leading zero number, duplicates, wrap of the awaited
  // number back to "not started", and a resync once the awaited one is absent.
  task automatic run_directed();
    srw_pkg::seq_t    d_seq[24];
    srw_pkg::handle_t h;
    d_seq = '{32'h0, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h5,
              32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
              32'h1009, 32'h100A, 32'h100B, 32'h100C, 32'h100D, 32'h100E,
              32'h100F, 32'h1010, 32'h1011, 32'h1012, 32'h1, 32'h6, 32'h5,
              32'h1234_5678, 32'hEDCB_A987};
    foreach (d_seq[i]) begin
      h = (i == 0) ? srw_pkg::handle_t'(0) :
          (i == 1) ? srw_pkg::handle_t'('1) : srw_pkg::handle_t'($urandom);
      send_packet(d_seq[i], h);
    end
  endtask

  // A mostly consecutive run with local swaps, a few gaps and duplicates.
  task automatic send_ordered_run();
    srw_pkg::seq_t base;
    srw_pkg::seq_t tmp;
    srw_pkg::seq_t run_seq[$];
    int            len;
    int            j;
    if ($urandom_range(0, 9) == 0)
      base = srw_pkg::seq_t'(32'hFFFF_FFFF - $urandom_range(0, 40));
    else base = srw_pkg::seq_t'($urandom);
    len = $urandom_range(24, 90);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 4) continue;
      run_seq.push_back(base + srw_pkg::seq_t'(i));
      if ($urandom_range(0, 99) < 3) run_seq.push_back(base + srw_pkg::seq_t'(i));
    end
    for (int i = 0; i + 1 < run_seq.size(); i++) begin
      if ($urandom_range(0, 99) < 35) begin
        j = i + $urandom_range(1, 3);
        if (j >= run_seq.size()) j = run_seq.size() - 1;
        tmp        = run_seq[i];
        run_seq[i] = run_seq[j];
        run_seq[j] = tmp;
      end
    end
    foreach (run_seq[i])
      send_packet(run_seq[i], srw_pkg::handle_t'($urandom_range(0, 65535)));
  endtask

  // Unrelated numbers, small ones often, to break runs and force resyncs.
  task automatic send_noise();
    int            count;
    srw_pkg::seq_t s;
    count = $urandom_range(1, 25);
    repeat (count) begin
      if ($urandom_range(0, 3) == 0) s = srw_pkg::seq_t'($urandom_range(0, 3));
      else s = srw_pkg::seq_t'($urandom);
      send_packet(s, srw_pkg::handle_t'($urandom_range(0, 65535)));
    end
  endtask

  task automatic run_random(int unsigned target);
    int unsigned stop_at;
    stop_at = sent + target;
    while (sent < stop_at) begin
      if ($urandom_range(0, 99) < 80) send_ordered_run();
      else send_noise();
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    run_directed();
    run_random(PHASE_ITEMS);
    send_idle_pct = 87;
    recv_idle_pct = 18;
    run_random(PHASE_ITEMS);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(PHASE_ITEMS);
    in_valid = 1'b0;

    // Drain outstanding releases, then watch for stray results.
    while (sb.due_releases.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d packets over three pacing phases; checked %0d releases", sb.packets,
             sb.releases);
    $display("and %0d resyncs, %0d errors.", sb.resyncs, sb.errors);
    if (sb.errors == 0 && sb.due_releases.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
